// ----- hw/rtl/kabf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kabf_pkg: shared types, constants and arithmetic helpers
// Word format, register reset values and controller command codes.
// ----------------------------------------------------------------------------
package kabf_pkg;

  localparam int DataWidth = 32;
  localparam int DivSteps  = 2 * DataWidth + 8; // 72 quotient bits

  localparam logic signed [DataWidth-1:0] WMax = {1'b0, {(DataWidth-1){1'b1}}};
  localparam logic signed [DataWidth-1:0] WMin = {1'b1, {(DataWidth-1){1'b0}}};

  localparam logic [30:0] AngleNoiseRst   = 31'd16777;
  localparam logic [30:0] BiasNoiseRst    = 31'd50331;
  localparam logic [30:0] MeasureNoiseRst = 31'd503316;

  localparam logic [1:0] RegAngleNoise   = 2'd0;
  localparam logic [1:0] RegBiasNoise    = 2'd1;
  localparam logic [1:0] RegMeasureNoise = 2'd2;

  typedef logic signed [DataWidth-1:0] word_t;

  // Multiplier operand selection
  localparam logic [3:0] OpNone  = 4'd0;
  localparam logic [3:0] OpLoad  = 4'd1;  // latch inputs, rate = gyro - bias
  localparam logic [3:0] OpAng   = 4'd2;  // angle += dt*rate
  localparam logic [3:0] OpD11   = 4'd3;  // d11 = dt*p11
  localparam logic [3:0] OpP00   = 4'd4;  // p00 += dt*t
  localparam logic [3:0] OpP11   = 4'd5;  // p11 += bias_noise*dt, s
  localparam logic [3:0] OpDiv0  = 4'd6;  // start k0 division
  localparam logic [3:0] OpDiv1  = 4'd7;  // start k1 division
  localparam logic [3:0] OpCorA  = 4'd8;  // angle += k0*y
  localparam logic [3:0] OpCorB  = 4'd9;  // bias += k1*y
  localparam logic [3:0] OpC00   = 4'd10;
  localparam logic [3:0] OpC01   = 4'd11;
  localparam logic [3:0] OpC10   = 4'd12;
  localparam logic [3:0] OpC11   = 4'd13;

  typedef struct packed {
    logic [3:0] op;
  } kabf_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic s_pos;
  } kabf_stat_t;

  function automatic word_t sat_add(input logic signed [DataWidth+1:0] v);
    word_t r;
    if (v > $signed({{2{WMax[DataWidth-1]}}, WMax})) r = WMax;
    else if (v < $signed({{2{WMin[DataWidth-1]}}, WMin})) r = WMin;
    else r = v[DataWidth-1:0];
    return r;
  endfunction

  // Round a signed product (ties away from zero) after a right shift of 24 (s24 set) or 16, saturate.
  function automatic word_t round_shift(input logic signed [2*DataWidth-1:0] p,
                                        input logic s24);
    logic                   neg;
    logic [2*DataWidth-1:0] m;
    logic [2*DataWidth-1:0] r;
    logic [2*DataWidth-1:0] q;
    word_t                  res;
    neg = p[2*DataWidth-1];
    m = neg ? (~p + 1'b1) : p;
    if (s24) begin
      r = m + (64'd1 << 23);
      q = r >> 24;
    end else begin
      r = m + (64'd1 << 15);
      q = r >> 16;
    end
    if (neg) begin
      if (q >= {32'd0, 1'b1, 31'd0}) res = WMin;
      else res = word_t'(-$signed(q[DataWidth-1:0]));
    end else begin
      if (q > {33'd0, 31'h7FFFFFFF}) res = WMax;
      else res = q[DataWidth-1:0];
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/kabf_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kabf_ctrl: sequencer
// Steps the datapath through predict, gain and correct for one transaction.
// ----------------------------------------------------------------------------
module kabf_ctrl
  import kabf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  logic       out_fire,
  input  kabf_stat_t stat,
  output kabf_cmd_t  cmd,
  output logic       in_ready,
  output logic       out_valid
);

  localparam logic [4:0] SIdle  = 5'd0;
  localparam logic [4:0] SAng   = 5'd1;
  localparam logic [4:0] SD11   = 5'd2;
  localparam logic [4:0] SP00   = 5'd3;
  localparam logic [4:0] SP11   = 5'd4;
  localparam logic [4:0] SDiv0  = 5'd5;
  localparam logic [4:0] SWait0 = 5'd6;
  localparam logic [4:0] SDiv1  = 5'd7;
  localparam logic [4:0] SWait1 = 5'd8;
  localparam logic [4:0] SCorA  = 5'd9;
  localparam logic [4:0] SCorB  = 5'd10;
  localparam logic [4:0] SC00   = 5'd11;
  localparam logic [4:0] SC01   = 5'd12;
  localparam logic [4:0] SC10   = 5'd13;
  localparam logic [4:0] SC11   = 5'd14;
  localparam logic [4:0] SOut   = 5'd15;
  localparam logic [4:0] SD11W  = 5'd16;
  localparam logic [4:0] SP11W  = 5'd17;

  logic [4:0] state;
  logic [4:0] state_next;

  assign in_ready  = (state == SIdle);
  assign out_valid = (state == SOut);

  always_comb begin
    state_next = state;
    cmd.op = OpNone;
    case (state)
      SIdle: begin
        if (in_fire) begin
          cmd.op = OpLoad;
          state_next = SAng;
        end
      end
      SAng:   begin cmd.op = OpAng; state_next = SD11; end
      SD11:   begin cmd.op = OpD11; state_next = SD11W; end
      // wait state so d11 is registered before it feeds the next product
      SD11W:  state_next = SP00;
      SP00:   begin cmd.op = OpP00; state_next = SP11; end
      SP11:   begin cmd.op = OpP11; state_next = SP11W; end
      // wait state so s is registered before the gain step
      SP11W:  state_next = SDiv0;
      SDiv0: begin
        if (stat.s_pos) begin
          cmd.op = OpDiv0;
          state_next = SWait0;
        end else begin
          state_next = SCorA; // gains stay zero
        end
      end
      SWait0: if (!stat.div_busy) state_next = SDiv1;
      SDiv1:  begin cmd.op = OpDiv1; state_next = SWait1; end
      SWait1: if (!stat.div_busy) state_next = SCorA;
      SCorA:  begin cmd.op = OpCorA; state_next = SCorB; end
      // bias rows first, so they read p00 and p01 before those are shrunk
      SCorB:  begin cmd.op = OpCorB; state_next = SC10; end
      SC10:   begin cmd.op = OpC10; state_next = SC11; end
      SC11:   begin cmd.op = OpC11; state_next = SC00; end
      SC00:   begin cmd.op = OpC00; state_next = SC01; end
      SC01:   begin cmd.op = OpC01; state_next = SOut; end
      SOut:   if (out_fire) state_next = SIdle;
      default: state_next = SIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= SIdle;
    else state <= state_next;
  end

endmodule

// ----- hw/rtl/kabf_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kabf_div: serial restoring divider
// Computes (n * 2^24) / d, truncated and saturated, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module kabf_div
  import kabf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  word_t num,
  input  word_t den,
  output logic  busy,
  output word_t quo
);

  localparam logic [32:0] QLim = {1'b1, 31'd0} + 33'd1;

  logic [DataWidth-1:0] nm;
  logic [DataWidth-1:0] dm;
  logic                 neg;
  logic [DataWidth:0]   rem;
  logic [32:0]          q;
  logic [6:0]           cnt;
  logic                 bit_in;
  logic [DataWidth:0]   rsh;
  logic [DataWidth:0]   rsub;
  logic [32:0]          qn;
  logic [32:0]          qs;

  // Leading zero bits above the numerator, then the numerator MSB first,
  // then 24 zero bits.
  always_comb begin
    if (cnt >= 7'd24 && cnt < 7'd56) bit_in = nm[5'(cnt - 7'd24)];
    else bit_in = 1'b0;
    rsh = {rem[DataWidth-1:0], bit_in};
    rsub = rsh - {1'b0, dm};
    qn = {q[31:0], 1'b0};
    if (rsh >= {1'b0, dm}) qn[0] = 1'b1;
    qs = (qn > QLim) ? QLim : qn;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == 7'd0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[DataWidth-1];
      nm  <= num[DataWidth-1] ? (~num + 1'b1) : num;
      dm  <= den;
      rem <= '0;
      q   <= '0;
      cnt <= 7'(DivSteps - 1);
    end else if (busy) begin
      rem <= (rsh >= {1'b0, dm}) ? rsub : rsh;
      q   <= qs;
      cnt <= cnt - 7'd1;
    end
  end

  always_comb begin
    if (neg) quo = (q >= {1'b0, 32'h80000000}) ? WMin : word_t'(-$signed(q[31:0]));
    else quo = (q > {2'b0, 31'h7FFFFFFF}) ? WMax : q[31:0];
  end

endmodule

// ----- hw/rtl/kabf_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kabf_dp: filter datapath
// State registers, one shared 32x32 multiplier with a product register,
// rounding and saturation, and the gain divider.
// ----------------------------------------------------------------------------
module kabf_dp
  import kabf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  kabf_cmd_t          cmd,
  output kabf_stat_t         stat,
  input  logic signed [24:0] measured_angle,
  input  logic signed [27:0] gyro_rate,
  input  logic [15:0]        time_step,
  input  logic [30:0]        angle_noise,
  input  logic [30:0]        bias_noise,
  input  logic [30:0]        measure_noise,
  output word_t              angle_out
);

  word_t angle, bias, p00, p01, p10, p11;
  word_t meas, dt, rate, d11, k0, k1, y, s;
  word_t ma, mb;
  word_t mr16, mr24, tval;
  word_t div_num, div_q;
  logic  div_start, div_busy, div_dst;
  logic  [3:0] op_q;

  // Operands for the combinational multiply of the current step
  always_comb begin
    ma = dt;
    mb = rate;
    tval = sat_add(34'(d11) - 34'(p01) - 34'(p10) + 34'({1'b0, angle_noise}));
    case (cmd.op)
      OpAng: begin ma = dt;  mb = rate; end
      OpD11: begin ma = dt;  mb = p11;  end
      OpP00: begin ma = dt;  mb = tval; end
      OpP11: begin ma = {1'b0, bias_noise}; mb = dt; end
      OpCorA: begin ma = k0; mb = y; end
      OpCorB: begin ma = k1; mb = y; end
      OpC00: begin ma = k0; mb = p00; end
      OpC01: begin ma = k0; mb = p01; end
      OpC10: begin ma = k1; mb = p00; end
      OpC11: begin ma = k1; mb = p01; end
      default: begin ma = dt; mb = rate; end
    endcase
  end

  logic signed [2*DataWidth-1:0] prod;
  always_ff @(posedge clk) begin
    prod <= ma * mb;
    op_q <= cmd.op;
  end

  assign mr16 = round_shift(prod, 1'b0);
  assign mr24 = round_shift(prod, 1'b1);

  assign div_start = (cmd.op == OpDiv0) || (cmd.op == OpDiv1);
  assign div_num   = (cmd.op == OpDiv0) ? p00 : p10;

  kabf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (s),
    .busy  (div_busy),
    .quo   (div_q)
  );

  logic div_busy_q;
  assign stat.div_busy = div_busy | div_start;
  assign stat.s_pos    = !s[DataWidth-1] && (s != '0);

  // Products are applied in the cycle after their step, overlapping the next step.
  always_ff @(posedge clk) begin
    if (rst) begin
      angle <= '0; bias <= '0;
      p00 <= '0; p01 <= '0; p10 <= '0; p11 <= '0;
      div_busy_q <= 1'b0;
      div_dst <= 1'b0;
    end else begin
      div_busy_q <= div_busy;
      if (div_start) div_dst <= (cmd.op == OpDiv1);
      if (div_busy_q && !div_busy) begin
        if (div_dst) k1 <= div_q;
        else k0 <= div_q;
      end
      if (cmd.op == OpLoad) begin
        meas <= word_t'(measured_angle);
        dt   <= {16'd0, time_step};
        rate <= sat_add(34'(word_t'(gyro_rate)) - 34'(bias));
        k0 <= '0;
        k1 <= '0;
      end
      case (op_q)
        OpAng: angle <= sat_add(34'(angle) + 34'(mr16));
        OpD11: d11 <= mr16;
        OpP00: begin
          p00 <= sat_add(34'(p00) + 34'(mr16));
          p01 <= sat_add(34'(p01) - 34'(d11));
          p10 <= sat_add(34'(p10) - 34'(d11));
        end
        OpP11: begin
          p11 <= sat_add(34'(p11) + 34'(mr16));
          s   <= sat_add(34'(p00) + 34'({1'b0, measure_noise}));
          y   <= sat_add(34'(meas) - 34'(angle));
        end
        OpCorA: angle <= sat_add(34'(angle) + 34'(mr24));
        OpCorB: bias  <= sat_add(34'(bias) + 34'(mr24));
        OpC00: p00 <= sat_add(34'(p00) - 34'(mr24));
        OpC01: p01 <= sat_add(34'(p01) - 34'(mr24));
        OpC10: p10 <= sat_add(34'(p10) - 34'(mr24));
        OpC11: p11 <= sat_add(34'(p11) - 34'(mr24));
        default: ;
      endcase
    end
  end

  assign angle_out = angle;

endmodule

// ----- hw/rtl/kalman_angle_bias_filter.sv -----
`timescale 1ns / 1ps
// The two divisions in the serial gain divider dominate the time from input
// to result; both are skipped when s is not positive (the gains stay zero).
// One transaction at a time: a new input is taken the cycle after the result
// leaves.
// Reset (rst, synchronous): estimates and covariance to zero, noise registers to
// their defaults.
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter: two-state angle and gyro bias Kalman filter
// Fuses a measured angle with a gyro rate; noise terms set over APB.
// ----------------------------------------------------------------------------
module kalman_angle_bias_filter
  import kabf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [24:0] measured_angle,
  input  logic signed [27:0] gyro_rate,
  input  logic [15:0]        time_step,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] filtered_angle
);

  logic [30:0] angle_noise, bias_noise, measure_noise;
  kabf_cmd_t   cmd;
  kabf_stat_t  stat;
  logic        in_fire, out_fire;

  assign pready = 1'b1;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_noise   <= AngleNoiseRst;
      bias_noise    <= BiasNoiseRst;
      measure_noise <= MeasureNoiseRst;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        RegAngleNoise:   angle_noise   <= pwdata[30:0];
        RegBiasNoise:    bias_noise    <= pwdata[30:0];
        RegMeasureNoise: measure_noise <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegAngleNoise:   prdata = {1'b0, angle_noise};
      RegBiasNoise:    prdata = {1'b0, bias_noise};
      RegMeasureNoise: prdata = {1'b0, measure_noise};
      default:         prdata = '0;
    endcase
  end

  kabf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .out_fire  (out_fire),
    .stat      (stat),
    .cmd       (cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid)
  );

  kabf_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .measured_angle (measured_angle),
    .gyro_rate      (gyro_rate),
    .time_step      (time_step),
    .angle_noise    (angle_noise),
    .bias_noise     (bias_noise),
    .measure_noise  (measure_noise),
    .angle_out      (filtered_angle)
  );

endmodule

// ----- tb/sv/kalman_angle_bias_filter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter_tb: self-checking bench for the angle/bias filter
// Drives sensor samples with random gaps and output stalls, and rewrites the
// noise registers between phases over APB. A local fixed-point filter model
// predicts every filtered angle, and each transaction is compared with it.
// ----------------------------------------------------------------------------
module kalman_angle_bias_filter_tb;
  import kabf_pkg::*;

  typedef struct {
    logic signed [24:0] meas;
    logic signed [27:0] gyro;
    logic [15:0]        dt;
  } sample_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_ready;
  logic signed [24:0] measured_angle;
  logic signed [27:0] gyro_rate;
  logic [15:0]        time_step;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] filtered_angle;

  sample_t     sample_q[$];
  logic [31:0] angle_expected_q[$];
  int          idle_mode;
  int          err_cnt;
  int          in_cnt;
  int          out_cnt;
  int          drv_seen;

  // filter model state and noise settings
  longint est_angle, est_bias;
  longint cov[4];
  longint q_angle, q_bias, r_meas;

  kalman_angle_bias_filter u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("kalman_angle_bias_filter_tb: done, errors");
    $finish;
  end

  function automatic longint clamp_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint word_from_mag(logic [63:0] m, bit neg);
    if (neg) return (m >= 64'h8000_0000) ? -64'sd2147483648 : -longint'(m);
    return (m > 64'h7FFF_FFFF) ? 64'sd2147483647 : longint'(m);
  endfunction

  // product shifted right by sh, rounded half away from zero
  function automatic longint mul_round(longint a, longint b, int sh);
    logic [63:0] ma, mb, prod;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    prod = ma * mb + (64'd1 << (sh - 1));
    return word_from_mag(prod >> sh, (a < 0) != (b < 0));
  endfunction

  // Q8.24 quotient, truncated toward zero; den is positive
  function automatic longint gain_div(longint num, longint den);
    logic [63:0] mn, q;
    mn = (num < 0) ? -num : num;
    q = (mn << 24) / den;
    if (q > 64'h8000_0001) q = 64'h8000_0001;
    return word_from_mag(q, num < 0);
  endfunction

  function automatic logic [31:0] predict_filtered_angle(sample_t s);
    longint meas, gyro, dt, rate, d11, tt, inov, k0, k1, y, c00, c01;
    meas = s.meas;
    gyro = s.gyro;
    dt = s.dt;
    k0 = 0;
    k1 = 0;
    rate = clamp_word(gyro - est_bias);
    est_angle = clamp_word(est_angle + mul_round(dt, rate, 16));
    d11 = mul_round(dt, cov[3], 16);
    tt = clamp_word(d11 - cov[1] - cov[2] + q_angle);
    cov[0] = clamp_word(cov[0] + mul_round(dt, tt, 16));
    cov[1] = clamp_word(cov[1] - d11);
    cov[2] = clamp_word(cov[2] - d11);
    cov[3] = clamp_word(cov[3] + mul_round(q_bias, dt, 16));
    inov = clamp_word(cov[0] + r_meas);
    // non-positive innovation variance: gains stay zero
    if (inov > 0) begin
      k0 = gain_div(cov[0], inov);
      k1 = gain_div(cov[2], inov);
    end
    y = clamp_word(meas - est_angle);
    est_angle = clamp_word(est_angle + mul_round(k0, y, 24));
    est_bias = clamp_word(est_bias + mul_round(k1, y, 24));
    c00 = cov[0];
    c01 = cov[1];
    cov[0] = clamp_word(cov[0] - mul_round(k0, c00, 24));
    cov[1] = clamp_word(cov[1] - mul_round(k0, c01, 24));
    cov[2] = clamp_word(cov[2] - mul_round(k1, c00, 24));
    cov[3] = clamp_word(cov[3] - mul_round(k1, c01, 24));
    return est_angle[31:0];
  endfunction

  // input driver: hold until accepted, otherwise maybe idle
  always @(negedge clk) begin
    int pct;
    pct = (idle_mode == 0) ? 33 : (idle_mode == 1) ? 63 : 0;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_cnt == drv_seen) begin
      in_valid <= 1'b1;
    end else if (sample_q.size() > 0 && $urandom_range(0, 99) >= pct) begin
      sample_t s;
      s = sample_q.pop_front();
      measured_angle <= s.meas;
      gyro_rate <= s.gyro;
      time_step <= s.dt;
      in_valid <= 1'b1;
      drv_seen = in_cnt;
    end else begin
      in_valid <= 1'b0;
      drv_seen = in_cnt;
    end
  end

  always @(negedge clk) begin
    int pct;
    pct = (idle_mode == 0) ? 63 : (idle_mode == 1) ? 33 : 0;
    out_ready <= !rst && ($urandom_range(0, 99) >= pct);
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      sample_t s;
      s.meas = measured_angle;
      s.gyro = gyro_rate;
      s.dt = time_step;
      angle_expected_q.push_back(predict_filtered_angle(s));
      in_cnt <= in_cnt + 1;
    end
    if (!rst && out_valid && out_ready) begin
      out_cnt <= out_cnt + 1;
      if (angle_expected_q.size() == 0) begin
        $error("filtered_angle: unexpected transaction, actual %0d", filtered_angle);
        err_cnt++;
      end else begin
        logic [31:0] exp_angle;
        exp_angle = angle_expected_q.pop_front();
        if (filtered_angle !== exp_angle) begin
          $error("filtered_angle: expected %0d, actual %0d",
                 $signed(exp_angle), filtered_angle);
          err_cnt++;
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegAngleNoise:   q_angle = val[30:0];
      RegBiasNoise:    q_bias = val[30:0];
      RegMeasureNoise: r_meas = val[30:0];
      default: ;
    endcase
  endtask

  task automatic set_noise(logic [31:0] qa, logic [31:0] qb, logic [31:0] rm);
    write_reg(RegAngleNoise, qa);
    write_reg(RegBiasNoise, qb);
    write_reg(RegMeasureNoise, rm);
  endtask

  task automatic add_sample(logic [24:0] m, logic [27:0] g, logic [15:0] d);
    sample_t s;
    s.meas = m;
    s.gyro = g;
    s.dt = d;
    sample_q.push_back(s);
  endtask

  task automatic drain();
    while (sample_q.size() > 0 || in_valid || angle_expected_q.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // mostly plausible IMU samples, a fifth full-range noise
  task automatic add_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0)
        add_sample($urandom, $urandom, $urandom);
      else
        add_sample($urandom_range(0, 11796480) - 5898240,
                   $urandom_range(0, 26214400) - 13107200,
                   ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 1500));
    end
  endtask

  task automatic run_phase(int mode, int n, bit pause_mid);
    idle_mode = mode;
    if (pause_mid) begin
      add_random(n / 2);
      // hold the sender until every result is back
      while (sample_q.size() > 0 || in_valid || angle_expected_q.size() > 0)
        @(posedge clk);
      add_random(n - n / 2);
    end else begin
      add_random(n);
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    measured_angle = '0;
    gyro_rate = '0;
    time_step = '0;
    idle_mode = 2;
    err_cnt = 0;
    in_cnt = 0;
    out_cnt = 0;
    drv_seen = 0;
    est_angle = 0;
    est_bias = 0;
    cov = '{0, 0, 0, 0};
    q_angle = AngleNoiseRst;
    q_bias = BiasNoiseRst;
    r_meas = MeasureNoiseRst;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: field extremes at reset noise settings
    add_sample(25'h0, 28'h0, 16'h0);
    add_sample(25'h0FF_FFFF, 28'h0, 16'd1000);
    add_sample(25'h100_0000, 28'h0, 16'd1000);
    add_sample(25'h0, 28'h7FF_FFFF, 16'hFFFF);
    add_sample(25'h0, 28'h800_0000, 16'hFFFF);
    add_sample(25'd11796480, 28'd131072000, 16'hFFFF);
    add_sample(-25'sd11796480, -28'sd131072000, 16'hFFFF);
    add_sample(25'h0FF_FFFF, 28'h7FF_FFFF, 16'hFFFF);
    add_sample(25'h100_0000, 28'h800_0000, 16'h0);
    add_sample(25'h1FF_FFFF, 28'hFFF_FFFF, 16'd1);
    for (int i = 0; i < 10; i++)
      add_sample(25'd655360, 28'd0, 16'd66);
    drain();

    set_noise(32'd200000, 32'd90000, 32'd1000000);
    run_phase(0, 300, 1'b0);
    set_noise(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    run_phase(1, 200, 1'b0);
    set_noise(32'd0, 32'd0, 32'd1);
    run_phase(2, 150, 1'b1);
    // zero measurement noise leaves the innovation variance equal to p00 alone
    set_noise($urandom_range(0, 100000), $urandom_range(0, 100000), 32'd0);
    run_phase(0, 100, 1'b0);
    set_noise(AngleNoiseRst, BiasNoiseRst, MeasureNoiseRst);
    run_phase(1, 150, 1'b0);

    $display("Covered %0d samples in, %0d filtered angles out, across six noise settings",
             in_cnt, out_cnt);
    $display("with idle and stall mixes, zero measurement noise and saturating inputs.");
    if (err_cnt == 0) begin
      $display("kalman_angle_bias_filter_tb: done, clean");
    end else begin
      $display("kalman_angle_bias_filter_tb: done, errors");
    end
    $finish;
  end

endmodule
